### hdl/subset_dp_hash_accumulator_unit_macros.svh
// Assertion macros for the subset DP hash accumulator checker.
// No dependencies; included by the checker file.
`ifndef SUBSET_DP_HASH_ACCUMULATOR_UNIT_MACROS_SVH
`define SUBSET_DP_HASH_ACCUMULATOR_UNIT_MACROS_SVH

// implication checked outside reset
`define SDHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdha check failed");

// next-cycle implication checked outside reset
`define SDHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdha check failed");

// condition in the cycle after reset
`define SDHA_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("sdha reset check failed");

`endif

### hdl/sdha_pkg.sv
// Package of the subset DP hash accumulator: widths, codes, states.
// No dependencies.
`default_nettype none
package sdha_pkg;
  localparam int TABLE_BITS_DEF = 16;
  localparam int MAX_NODES = 16;
  localparam int MASK_W = 16;
  localparam int VERT_W = 5;
  localparam int KEY_W = MASK_W + VERT_W;
  localparam int CNT_W = 64;
  localparam int OCC_W = 17;
  localparam int NUM_W = 5;
  localparam int HASH_SHIFT = 64 - 30;
  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] ALL_ONES = 64'hFFFFFFFFFFFFFFFF;
  localparam logic [4:0] NODE_COUNT_RST = 5'd16;

  localparam logic [1:0] ACT_EXPAND = 2'd0;
  localparam logic [1:0] ACT_DRAIN = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_DRAINED = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAND,
    S_HASH_LO,
    S_HASH_HI,
    S_HASH_ADDR,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DRAIN_RD,
    S_DRAIN_CHK,
    S_RESULT
  } state_t;
endpackage
`default_nettype wire

### hdl/sdha_if.sv
// Channel interfaces of the subset DP hash accumulator: command, response, config.
// Depends on sdha_pkg.
`default_nettype none
interface sdha_cmd_if;
  import sdha_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [MASK_W-1:0] entry_mask;
  logic [3:0] end_vertex;
  logic [CNT_W-1:0] entry_count;
  modport source (output valid, action, entry_mask, end_vertex, entry_count, input ready);
  modport sink (input valid, action, entry_mask, end_vertex, entry_count, output ready);
endinterface

interface sdha_rsp_if;
  import sdha_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [NUM_W-1:0] new_slots;
  logic [NUM_W-1:0] dropped_inserts;
  logic saturated;
  logic [MASK_W-1:0] out_mask;
  logic [3:0] out_vertex;
  logic [CNT_W-1:0] out_value;
  logic [OCC_W-1:0] occupied;
  logic last;
  modport source (output valid, status, new_slots, dropped_inserts, saturated, out_mask,
                  out_vertex, out_value, occupied, last, input ready);
  modport sink (input valid, status, new_slots, dropped_inserts, saturated, out_mask,
                out_vertex, out_value, occupied, last, output ready);
endinterface

interface sdha_cfg_if;
  logic valid;
  logic ready;
  logic [4:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface
`default_nettype wire

### hdl/subset_dp_hash_accumulator_unit.sv
// Subset DP hash accumulator top level: FSM, hash unit and probe logic over one RAM.
// Depends on sdha_pkg, sdha_if and sdha_ram.
//
// Usage: commands arrive on cmd (expand, drain, clear); each expand, drain or clear
// gives exactly one transfer on rsp, an unknown action is taken and gives none.
// The user writes node_count on cfg only while the block is idle; the block does not enforce it.
// The table lives in one single-port RAM of 2^TABLE_BITS words {valid, key, value}.
// Expand: each candidate vertex is checked in S_CAND; a vertex that is not skipped is hashed
// (S_HASH_LO, S_HASH_HI, S_HASH_ADDR) and probed, each probe in S_PROBE_RD and S_PROBE_CHK.
// Skipped vertices stay in S_CAND. The 21x64 hash multiply is split into a low and a high part.
// Drain: slots are read and checked from the drain pointer until a valid one or the end.
// Clear: one RAM word per cycle, over all 2^TABLE_BITS words.
// After reset the same clearing pass runs with no response;
// cmd.ready stays low meanwhile, cfg is always ready.
// The response sits in an output register; when rsp is stalled the block waits in
// S_RESULT with its result until the register frees, and takes no new command meanwhile.
`default_nettype none
module subset_dp_hash_accumulator_unit #(
  parameter int TABLE_BITS = sdha_pkg::TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sdha_cmd_if.sink    cmd,
  sdha_rsp_if.source  rsp,
  sdha_cfg_if.sink    cfg
);
  import sdha_pkg::*;

  localparam int ADDR_W = TABLE_BITS;
  localparam int PTR_W = TABLE_BITS + 1;
  localparam int WORD_W = 1 + KEY_W + CNT_W;

  state_t state, state_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [CNT_W-1:0]  rd_val;

  logic [4:0]          node_count;
  logic [MASK_W-1:0]   mask;
  logic [3:0]          vtx;
  logic [CNT_W-1:0]    cnt;
  logic [VERT_W-1:0]   u;
  logic [KEY_W-1:0]    key;
  logic [CNT_W-1:0]    weight;
  logic [KEY_W+31:0]   p_lo;
  logic [31:0]         p_hi;
  logic [ADDR_W-1:0]   paddr;
  logic [ADDR_W-1:0]   probes;
  logic [NUM_W-1:0]    claimed;
  logic [NUM_W-1:0]    dropped;
  logic                sat;
  logic [PTR_W-1:0]    occ;
  logic [PTR_W-1:0]    dptr;
  logic [ADDR_W-1:0]   clr_ptr;
  logic                clr_report;
  logic [1:0]          res_status;
  logic                res_last;
  logic [KEY_W-1:0]    dr_key;
  logic [CNT_W-1:0]    dr_val;

  logic                rsp_valid;
  logic [1:0]          rsp_status;
  logic [NUM_W-1:0]    rsp_new;
  logic [NUM_W-1:0]    rsp_drop;
  logic                rsp_sat;
  logic [KEY_W-1:0]    rsp_key;
  logic [CNT_W-1:0]    rsp_val;
  logic [OCC_W-1:0]    rsp_occ;
  logic                rsp_last;

  logic [4:0]          n_eff;
  logic                cand_end;
  logic                cand_skip;
  logic                dbl;
  logic [CNT_W:0]      dbl_sum;
  logic [CNT_W:0]      upd_sum;
  logic [KEY_W-1:0]    key_now;
  logic [63:0]         hash_sum;
  logic                hit;
  logic                full_miss;
  logic                out_free;

  function automatic logic [CNT_W-1:0] sat_val(input logic [CNT_W:0] s);
    return s[CNT_W] ? ALL_ONES : s[CNT_W-1:0];
  endfunction

  sdha_ram #(.WIDTH(WORD_W), .ADDR_W(ADDR_W)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_key = ram_rdata[CNT_W +: KEY_W];
  assign rd_val = ram_rdata[CNT_W-1:0];

  always_comb begin
    n_eff = node_count;
    if (n_eff > 5'(MAX_NODES)) begin
      n_eff = 5'(MAX_NODES);
    end
    if (n_eff > 5'd16) begin
      n_eff = 5'd16;
    end
  end

  assign cand_end = u >= n_eff;
  assign cand_skip = mask[u[3:0]] || ((vtx != 4'd0) && (u == ({1'b0, vtx} - 5'd1)));
  assign dbl = u == ({1'b0, vtx} + 5'd1);
  assign dbl_sum = {1'b0, cnt} + {1'b0, cnt};
  assign upd_sum = {1'b0, rd_val} + {1'b0, weight};
  assign key_now = {mask | (MASK_W'(1) << u[3:0]), u};
  assign hash_sum = 64'(p_lo) + {p_hi, 32'd0};
  assign hit = rd_key == key;
  assign full_miss = probes == '1;
  assign out_free = !rsp_valid || rsp.ready;

  assign cmd.ready = state == S_IDLE;
  assign cfg.ready = 1'b1;

  assign rsp.valid = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.new_slots = rsp_new;
  assign rsp.dropped_inserts = rsp_drop;
  assign rsp.saturated = rsp_sat;
  assign rsp.out_mask = rsp_key[KEY_W-1:VERT_W];
  assign rsp.out_vertex = rsp_key[3:0];
  assign rsp.out_value = rsp_val;
  assign rsp.occupied = rsp_occ;
  assign rsp.last = rsp_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_addr = paddr;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_ptr;
        if (clr_ptr == '1) begin
          state_next = clr_report ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.action)
            ACT_EXPAND: state_next = S_CAND;
            ACT_DRAIN:  state_next = S_DRAIN_RD;
            ACT_CLEAR:  state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CAND: begin
        if (cand_end) begin
          state_next = S_RESULT;
        end else if (!cand_skip) begin
          state_next = S_HASH_LO;
        end
      end
      S_HASH_LO:   state_next = S_HASH_HI;
      S_HASH_HI:   state_next = S_HASH_ADDR;
      S_HASH_ADDR: state_next = S_PROBE_RD;
      S_PROBE_RD:  state_next = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!rd_valid) begin
          ram_we = 1'b1;
          ram_wdata = {1'b1, key, weight};
          state_next = S_CAND;
        end else if (hit) begin
          ram_we = 1'b1;
          ram_wdata = {1'b1, key, sat_val(upd_sum)};
          state_next = S_CAND;
        end else if (full_miss) begin
          state_next = S_CAND;
        end else begin
          state_next = S_PROBE_RD;
        end
      end
      S_DRAIN_RD: begin
        ram_addr = dptr[ADDR_W-1:0];
        state_next = dptr[ADDR_W] ? S_RESULT : S_DRAIN_CHK;
      end
      S_DRAIN_CHK: begin
        ram_addr = dptr[ADDR_W-1:0];
        state_next = rd_valid ? S_RESULT : S_DRAIN_RD;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      occ <= '0;
      dptr <= '0;
      clr_ptr <= '0;
      clr_report <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        node_count <= cfg.node_count;
      end
      if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
        end
        S_IDLE: begin
          mask <= cmd.entry_mask;
          vtx <= cmd.end_vertex;
          cnt <= cmd.entry_count;
          u <= '0;
          claimed <= '0;
          dropped <= '0;
          sat <= 1'b0;
          res_last <= 1'b0;
          dr_key <= '0;
          dr_val <= '0;
          if (cmd.valid && cmd.action == ACT_CLEAR) begin
            clr_ptr <= '0;
            clr_report <= 1'b1;
            occ <= '0;
            dptr <= '0;
            res_status <= ST_FIN;
          end
        end
        S_CAND: begin
          if (cand_end) begin
            res_status <= (dropped != '0) ? ST_DROP : ST_DONE;
          end else if (cand_skip) begin
            u <= u + 1'b1;
          end else begin
            key <= key_now;
            weight <= dbl ? sat_val(dbl_sum) : cnt;
            if (dbl && dbl_sum[CNT_W]) begin
              sat <= 1'b1;
            end
          end
        end
        S_HASH_LO: begin
          p_lo <= (KEY_W+32)'(key) * (KEY_W+32)'(HASH_MULT[31:0]);
        end
        S_HASH_HI: begin
          p_hi <= 32'(key) * HASH_MULT[63:32];
        end
        S_HASH_ADDR: begin
          paddr <= hash_sum[HASH_SHIFT +: ADDR_W];
          probes <= '0;
        end
        S_PROBE_CHK: begin
          if (!rd_valid) begin
            occ <= occ + 1'b1;
            claimed <= claimed + 1'b1;
            u <= u + 1'b1;
          end else if (hit) begin
            if (upd_sum[CNT_W]) begin
              sat <= 1'b1;
            end
            u <= u + 1'b1;
          end else if (full_miss) begin
            dropped <= dropped + 1'b1;
            u <= u + 1'b1;
          end else begin
            paddr <= paddr + 1'b1;
            probes <= probes + 1'b1;
          end
        end
        S_DRAIN_RD: begin
          if (dptr[ADDR_W]) begin
            dptr <= '0;
            res_status <= ST_FIN;
            res_last <= 1'b1;
          end
        end
        S_DRAIN_CHK: begin
          dptr <= dptr + 1'b1;
          if (rd_valid) begin
            dr_key <= rd_key;
            dr_val <= rd_val;
            res_status <= ST_DRAINED;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp_status <= res_status;
            rsp_new <= claimed;
            rsp_drop <= dropped;
            rsp_sat <= sat;
            rsp_key <= dr_key;
            rsp_val <= dr_val;
            rsp_occ <= OCC_W'(occ);
            rsp_last <= res_last;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/sdha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sdha_ram #(
  parameter int WIDTH = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hdl/sdha_checker.sv
// Port-level assertions for the subset DP hash accumulator, bound to the top level.
// Depends on sdha_pkg and subset_dp_hash_accumulator_unit_macros.svh.
`default_nettype none
`include "subset_dp_hash_accumulator_unit_macros.svh"
module sdha_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] rsp_status,
  input wire logic [4:0] rsp_dropped,
  input wire logic       rsp_last
);
  import sdha_pkg::*;

  `SDHA_ASSERT_RST(a_rst_no_rsp, !rsp_valid)
  `SDHA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
  `SDHA_ASSERT_IMP(a_done_no_drop, rsp_valid && rsp_status == ST_DONE, rsp_dropped == 5'd0)
  `SDHA_ASSERT_IMP(a_drained_not_last, rsp_valid && rsp_status == ST_DRAINED, !rsp_last)
endmodule

bind subset_dp_hash_accumulator_unit sdha_checker u_sdha_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_dropped (rsp.dropped_inserts),
  .rsp_last    (rsp.last)
);
`default_nettype wire

### dv/testbench.sv
// Testbench of subset_dp_hash_accumulator_unit: directed and random expand, drain and clear
// commands, checked against an in-bench hash table with saturating counts.
// Depends on sdha_pkg, sdha_if and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
  import sdha_pkg::*;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] mask;
    logic [3:0]  vert;
    logic [63:0] count;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  new_slots;
    logic [4:0]  dropped;
    logic        sat;
    logic [15:0] mask;
    logic [3:0]  vert;
    logic [63:0] value;
    logic [16:0] occ;
    logic        last;
  } rsp_item_t;

  localparam int SLOTS = 1 << TABLE_BITS_DEF;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic clk;
  logic rst;

  sdha_cmd_if cmd_if();
  sdha_rsp_if rsp_if();
  sdha_cfg_if cfg_if();

  subset_dp_hash_accumulator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  cmd_item_t   cmd_q[$];
  rsp_item_t   pending_results[$];
  logic [20:0] tbl_key[int];
  logic [63:0] tbl_val[int];
  int unsigned tbl_occ;
  int unsigned drain_ptr;
  logic [4:0]  node_count;
  logic [15:0] mask_pool[8];
  logic [4:0]  phase_nodes[6];
  bit          cmd_took;
  bit          calm;
  int          rx_hold;
  int          errors;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned home_slot(logic [20:0] key);
    logic [63:0] prod;
    prod = {43'd0, key} * HASH_MULT;
    return prod[HASH_SHIFT+TABLE_BITS_DEF-1:HASH_SHIFT];
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, ref logic sat);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat = 1'b1;
      return ALL_ONES;
    end
    return s[63:0];
  endfunction

  // 0 update, 1 claim, 2 drop
  function automatic int table_insert(logic [20:0] key, logic [63:0] weight, ref logic sat);
    int unsigned h;
    h = home_slot(key);
    for (int p = 0; p < SLOTS; p++) begin
      if (!tbl_key.exists(h)) begin
        tbl_key[h] = key;
        tbl_val[h] = weight;
        tbl_occ++;
        return 1;
      end
      if (tbl_key[h] == key) begin
        tbl_val[h] = sat_add(tbl_val[h], weight, sat);
        return 0;
      end
      h = (h + 1) % SLOTS;
    end
    return 2;
  endfunction

  function automatic void apply_command(cmd_item_t it);
    rsp_item_t r;
    int unsigned n, p, claimed, dropped;
    logic [63:0] w;
    logic sat;
    int res;
    if (it.action == ACT_UNKNOWN) return;
    r = '{default: '0};
    if (it.action == ACT_EXPAND) begin
      n = node_count;
      if (n > MAX_NODES) n = MAX_NODES;
      if (n > 16) n = 16;
      claimed = 0;
      dropped = 0;
      sat = 1'b0;
      for (int unsigned u = 0; u < n; u++) begin
        if (it.mask[u]) continue;
        if (it.vert != 0 && u == it.vert - 1) continue;
        w = it.count;
        if (u == it.vert + 1) w = sat_add(it.count, it.count, sat);
        res = table_insert({it.mask | (16'd1 << u), u[4:0]}, w, sat);
        if (res == 1) claimed++;
        else if (res == 2) dropped++;
      end
      r.status = dropped != 0 ? ST_DROP : ST_DONE;
      r.new_slots = claimed[4:0];
      r.dropped = dropped[4:0];
      r.sat = sat;
    end else if (it.action == ACT_DRAIN) begin
      p = drain_ptr;
      while (p < SLOTS && !tbl_key.exists(p)) p++;
      if (p < SLOTS) begin
        r.status = ST_DRAINED;
        r.mask = tbl_key[p][20:5];
        r.vert = tbl_key[p][3:0];
        r.value = tbl_val[p];
        drain_ptr = p + 1;
      end else begin
        r.status = ST_FIN;
        r.last = 1'b1;
        drain_ptr = 0;
      end
    end else begin
      tbl_key.delete();
      tbl_val.delete();
      tbl_occ = 0;
      drain_ptr = 0;
      r.status = ST_FIN;
    end
    r.occ = tbl_occ[16:0];
    pending_results.push_back(r);
  endfunction

  // command side
  always @(posedge clk) begin
    cmd_took = cmd_if.valid && cmd_if.ready;
    if (cmd_took)
      apply_command('{cmd_if.action, cmd_if.entry_mask, cmd_if.end_vertex, cmd_if.entry_count});
  end

  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_took) begin
      if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
        it = cmd_q.pop_front();
        cmd_if.valid <= 1'b1;
        cmd_if.action <= it.action;
        cmd_if.entry_mask <= it.mask;
        cmd_if.end_vertex <= it.vert;
        cmd_if.entry_count <= it.count;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // response side
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= calm || $urandom_range(99) >= 22;
    end
  end

  always @(posedge clk) begin
    rsp_item_t e;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer on response channel");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp_if.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_if.status); errors++;
        end
        if (rsp_if.new_slots !== e.new_slots) begin
          $error("new_slots exp %0d got %0d", e.new_slots, rsp_if.new_slots); errors++;
        end
        if (rsp_if.dropped_inserts !== e.dropped) begin
          $error("dropped_inserts exp %0d got %0d", e.dropped, rsp_if.dropped_inserts);
          errors++;
        end
        if (rsp_if.saturated !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, rsp_if.saturated); errors++;
        end
        if (rsp_if.out_mask !== e.mask) begin
          $error("out_mask exp %h got %h", e.mask, rsp_if.out_mask); errors++;
        end
        if (rsp_if.out_vertex !== e.vert) begin
          $error("out_vertex exp %0d got %0d", e.vert, rsp_if.out_vertex); errors++;
        end
        if (rsp_if.out_value !== e.value) begin
          $error("out_value exp %h got %h", e.value, rsp_if.out_value); errors++;
        end
        if (rsp_if.occupied !== e.occ) begin
          $error("occupied exp %0d got %0d", e.occ, rsp_if.occupied); errors++;
        end
        if (rsp_if.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, rsp_if.last); errors++;
        end
      end
    end
  end

  task automatic push_cmd(logic [1:0] a, logic [15:0] m, logic [3:0] v, logic [63:0] c);
    cmd_q.push_back('{a, m, v, c});
  endtask

  task automatic push_random(int count);
    int sel;
    logic [15:0] m;
    logic [63:0] c;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      m = $urandom_range(99) < 70 ? mask_pool[$urandom_range(7)] : 16'($urandom);
      case ($urandom_range(3))
        0: c = {32'hFFFF_FFFF, 32'($urandom)};
        1: c = 64'($urandom_range(15));
        default: c = {32'($urandom), 32'($urandom)};
      endcase
      if (sel < 86) push_cmd(ACT_EXPAND, m, 4'($urandom), c);
      else if (sel < 97) push_cmd(ACT_DRAIN, 16'($urandom), 4'($urandom), c);
      else push_cmd(ACT_UNKNOWN, m, 4'($urandom), c);
    end
  endtask

  task automatic wait_results;
    while (cmd_q.size() > 0 || cmd_if.valid || pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic write_nodes(logic [4:0] value);
    wait_results();
    repeat (200) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.node_count <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    node_count = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    phase_nodes = '{5'd2, 5'd0, 5'd1, 5'd31, 5'd9, 5'd16};
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_EXPAND;
    cmd_if.entry_mask = '0;
    cmd_if.end_vertex = '0;
    cmd_if.entry_count = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.node_count = NODE_COUNT_RST;
    node_count = NODE_COUNT_RST;
    tbl_occ = 0;
    drain_ptr = 0;
    errors = 0;
    rx_hold = 0;
    calm = 1'b0;
    cmd_took = 1'b0;
    for (int i = 0; i < 8; i++) mask_pool[i] = 16'($urandom & $urandom & $urandom);
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_nodes(5'd16);
    push_cmd(ACT_EXPAND, 16'h0000, 4'd0, 64'd1);
    push_cmd(ACT_EXPAND, 16'h0000, 4'd0, 64'd1);
    push_cmd(ACT_EXPAND, 16'hFFFF, 4'd5, 64'd7);
    push_cmd(ACT_EXPAND, 16'h0000, 4'd3, ALL_ONES);
    push_cmd(ACT_EXPAND, 16'h0000, 4'd15, 64'h8000_0000_0000_0000);
    push_cmd(ACT_EXPAND, 16'h5555, 4'd0, 64'd0);
    push_cmd(ACT_EXPAND, 16'hAAAA, 4'd14, 64'd3);
    push_cmd(ACT_EXPAND, 16'h0001, 4'd1, 64'd5);
    push_cmd(ACT_UNKNOWN, 16'hFFFF, 4'd15, ALL_ONES);
    repeat (3) push_cmd(ACT_DRAIN, 16'h0, 4'd0, 64'd0);
    push_cmd(ACT_CLEAR, 16'h0, 4'd0, 64'd0);
    push_cmd(ACT_DRAIN, 16'h0, 4'd0, 64'd0);
    push_cmd(ACT_EXPAND, 16'h0000, 4'd0, 64'd2);
    repeat (17) push_cmd(ACT_DRAIN, 16'h0, 4'd0, 64'd0);

    for (int ph = 0; ph < 6; ph++) begin
      write_nodes(phase_nodes[ph]);
      if (ph == 2) rx_hold = 400;
      calm = (ph == 4);
      if (ph == 3) begin
        push_random(150);
        wait_results();
        push_random(150);
      end else begin
        push_random(300);
      end
      if (ph == 1 || ph == 3) push_cmd(ACT_CLEAR, 16'h0, 4'd0, 64'd0);
    end
    calm = 1'b0;
    push_random(30);
    wait_results();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // a drain may scan the whole table, so the bound is set by full-table sweeps
  initial begin
    #1s;
    $display("FAIL");
    $finish;
  end
endmodule
